// ===== rtl/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg: shared types and constants for the double-ended priority queue
// Holds the store size, the command codes, the broadcast operation type and
// the link between neighboring cells of the sorted chain.
// ----------------------------------------------------------------------------
`default_nettype none

package depq_pkg;

  // Store size and derived widths
  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W  = 7;

  // Max reduction tree: first level ORs groups of this many taps
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_MAX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_MIN = 2'd2;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DEL_MAX,
    OP_DEL_MIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [DATA_W-1:0]  value;
  } op_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      gt;     // valid and entry above the insert value
    logic signed [DATA_W-1:0]  entry;
  } link_t;

endpackage

`default_nettype wire

// ===== rtl/depq_cell.sv =====
// ----------------------------------------------------------------------------
// depq_cell: one slot of the sorted chain
// Holds one entry and its valid flag. On insert it keeps, takes the new
// value or takes its lower neighbor's entry; on delete-min it takes its upper
// neighbor's entry; on delete-max the topmost valid cell drops out.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire depq_pkg::op_t                      op,
  input  wire depq_pkg::link_t                    lower,
  input  wire depq_pkg::link_t                    upper,
  output depq_pkg::link_t                         self_link,
  output logic        [depq_pkg::DATA_W-1:0]      tap
);

  logic                                 valid;
  logic                                 valid_next;
  logic signed [depq_pkg::DATA_W-1:0]   entry;
  logic signed [depq_pkg::DATA_W-1:0]   entry_next;
  logic                                 gt;

  // Compare against the value being inserted
  assign gt = valid && ($signed(entry) > $signed(op.value));

  assign self_link.valid = valid;
  assign self_link.gt    = gt;
  assign self_link.entry = entry;

  // Topmost valid cell offers its entry to the max tree
  assign tap = (valid && !upper.valid) ? entry : '0;

  // Next state from the broadcast operation and the neighbors
  always_comb begin
    valid_next = valid;
    entry_next = entry;
    case (op.kind)
      depq_pkg::OP_INSERT: begin
        valid_next = valid || lower.valid;
        if (lower.gt) begin
          entry_next = lower.entry;
        end else if (gt || !valid) begin
          entry_next = op.value;
        end
      end
      depq_pkg::OP_DEL_MAX: begin
        valid_next = valid && upper.valid;
      end
      depq_pkg::OP_DEL_MIN: begin
        valid_next = upper.valid;
        entry_next = upper.entry;
      end
      default: begin
        valid_next = valid;
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Entry payload needs no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== rtl/depq_max_tree.sv =====
// ----------------------------------------------------------------------------
// depq_max_tree: registered OR tree that picks out the largest entry
// At most one cell tap is nonzero (the topmost valid cell), so an OR over
// all taps yields the maximum. First level is registered per group.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_max_tree (
  input  wire logic                          clk,
  input  wire logic [depq_pkg::DATA_W-1:0]   taps [depq_pkg::CAPACITY],
  output logic      [depq_pkg::DATA_W-1:0]   max_value
);

  logic [depq_pkg::DATA_W-1:0] group_or      [depq_pkg::NUM_GROUPS];
  logic [depq_pkg::DATA_W-1:0] group_or_next [depq_pkg::NUM_GROUPS];

  // First level: OR within each group
  always_comb begin
    for (int g = 0; g < depq_pkg::NUM_GROUPS; g++) begin
      group_or_next[g] = '0;
      for (int k = 0; k < depq_pkg::GROUP_SIZE; k++) begin
        if (g * depq_pkg::GROUP_SIZE + k < depq_pkg::CAPACITY) begin
          group_or_next[g] = group_or_next[g] | taps[g * depq_pkg::GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < depq_pkg::NUM_GROUPS; g++) begin
      group_or[g] <= group_or_next[g];
    end
  end

  // Second level: OR across the group registers
  always_comb begin
    max_value = '0;
    for (int g = 0; g < depq_pkg::NUM_GROUPS; g++) begin
      max_value = max_value | group_or[g];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/double_ended_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit: bounded sorted store with min/max delete
// Each input transaction carries a command (insert, delete max, delete min)
// and a value. Each one gives exactly one output transaction with the
// current max and min (0 when empty), the count, an empty flag and a flag
// for an insert refused because the store was full.
//
// Input: in_valid/in_stall with command and value. Output: out_valid/
// out_stall with the result fields, held in an output register.
// Flow: the sorted chain of cells updates at the accept edge; the max
// reduction tree adds one registered level, and after it the result enters
// the output register once that register is free. Items are taken one at
// a time; in_stall drops again as soon as the result is in
// the output register, so the next item is taken while it waits there.
// When the receiver stalls, the finished result sits in the output
// register; a second result waits in the tree until the register frees up.
// Reset (rst, synchronous) empties the store and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic        [depq_pkg::CMD_W-1:0]    command,
  input  wire logic signed [depq_pkg::DATA_W-1:0]   value,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [depq_pkg::DATA_W-1:0]   max_value,
  output logic signed      [depq_pkg::DATA_W-1:0]   min_value,
  output logic             [depq_pkg::OUT_CNT_W-1:0] entry_count,
  output logic                                      is_empty,
  output logic                                      insert_dropped
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_DELIVER
  } state_t;

  state_t                                state;
  logic [depq_pkg::COUNT_W-1:0]          count;
  logic                                  dropped;
  logic                                  accept;
  logic                                  full;
  logic                                  out_free;
  depq_pkg::op_t                         op;
  depq_pkg::link_t                       links [depq_pkg::CAPACITY];
  logic [depq_pkg::DATA_W-1:0]           taps  [depq_pkg::CAPACITY];
  logic [depq_pkg::DATA_W-1:0]           tree_max;
  logic [depq_pkg::COUNT_W+depq_pkg::OUT_CNT_W-1:0] count_ext;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == depq_pkg::COUNT_W'(depq_pkg::CAPACITY));
  assign out_free = !out_valid || !out_stall;

  // Command decode into the broadcast operation
  always_comb begin
    op.value = value;
    op.kind  = depq_pkg::OP_NONE;
    if (accept) begin
      case (command)
        depq_pkg::CMD_INSERT:  op.kind = full ? depq_pkg::OP_NONE : depq_pkg::OP_INSERT;
        depq_pkg::CMD_DEL_MAX: op.kind = depq_pkg::OP_DEL_MAX;
        depq_pkg::CMD_DEL_MIN: op.kind = depq_pkg::OP_DEL_MIN;
        default:               op.kind = depq_pkg::OP_NONE;
      endcase
    end
  end

  // Sorted chain of cells, ascending from cell 0
  for (genvar i = 0; i < depq_pkg::CAPACITY; i++) begin : g_cell
    depq_pkg::link_t lower;
    depq_pkg::link_t upper;

    if (i == 0) begin : g_bottom
      assign lower = '{valid: 1'b1, gt: 1'b0, entry: '0};
    end else begin : g_lower
      assign lower = links[i-1];
    end

    if (i == depq_pkg::CAPACITY - 1) begin : g_top
      assign upper = '{valid: 1'b0, gt: 1'b0, entry: '0};
    end else begin : g_upper
      assign upper = links[i+1];
    end

    depq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .lower     (lower),
      .upper     (upper),
      .self_link (links[i]),
      .tap       (taps[i])
    );
  end

  depq_max_tree u_max_tree (
    .clk       (clk),
    .taps      (taps),
    .max_value (tree_max)
  );

  // Count mapped onto the 7-bit result field
  assign count_ext = {{depq_pkg::OUT_CNT_W{1'b0}}, count};

  // Control, count and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            dropped <= 1'b0;
            case (command)
              depq_pkg::CMD_INSERT: begin
                if (full) begin
                  dropped <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              depq_pkg::CMD_DEL_MAX, depq_pkg::CMD_DEL_MIN: begin
                if (count != '0) begin
                  count <= count - 1'b1;
                end
              end
              default: begin
                count <= count;
              end
            endcase
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          state <= S_DELIVER;
        end
        S_DELIVER: begin
          if (out_free) begin
            max_value      <= tree_max;
            min_value      <= (count == '0) ? '0 : links[0].entry;
            entry_count    <= count_ext[depq_pkg::OUT_CNT_W-1:0];
            is_empty       <= (count == '0);
            insert_dropped <= dropped;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Output valid: set when a result is loaded, cleared once taken
      if (state == S_DELIVER && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/depq_checker.sv =====
// ----------------------------------------------------------------------------
// depq_checker: port-level assertions for the priority queue unit
// Watches only the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_port_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic signed [depq_pkg::DATA_W-1:0]   max_value,
  input wire logic signed [depq_pkg::DATA_W-1:0]   min_value,
  input wire logic        [depq_pkg::OUT_CNT_W-1:0] entry_count,
  input wire logic                                 is_empty,
  input wire logic                                 insert_dropped
);

  // A stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction withdrawn while stalled");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // Empty store reports zero extremes
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (max_value == '0) && (min_value == '0))
    else $error("empty store shows nonzero max or min");

  // Sorted store: max never below min
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> ($signed(max_value) >= $signed(min_value)))
    else $error("max below min");

  // A refused insert only happens on a full store
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && insert_dropped |->
      (entry_count == depq_pkg::OUT_CNT_W'(depq_pkg::CAPACITY)))
    else $error("insert dropped while store not full");

endmodule

bind double_ended_priority_queue_unit depq_port_checker u_depq_checker (.*);

`default_nettype wire
